FILE: rtl/core/acp_pkg.sv
// shared types, command codes and response byte tables for the packet device
package acp_pkg;

    // device bus phase
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_PACKET = 2'd1,
        PH_DATA   = 2'd2,
        PH_STATUS = 2'd3
    } t_phase;

    // host action codes
    typedef enum logic [2:0] {
        ACT_RESET = 3'd0,
        ACT_BEGIN = 3'd1,
        ACT_WORD  = 3'd2,
        ACT_READ  = 3'd3,
        ACT_CLEAR = 3'd4
    } t_action;

    // kind of data held in the response store
    typedef enum logic [1:0] {
        K_SENSE = 2'd0,
        K_INQ   = 2'd1,
        K_CAP   = 2'd2,
        K_TOC   = 2'd3
    } t_kind;

    // configuration register indexes
    localparam logic [1:0] CFG_MEDIA    = 2'd0;
    localparam logic [1:0] CFG_SECTORS  = 2'd1;
    localparam logic [1:0] CFG_CAPACITY = 2'd2;

    // command opcodes
    localparam logic [7:0] OP_TEST_READY = 8'h00;
    localparam logic [7:0] OP_REQ_SENSE  = 8'h03;
    localparam logic [7:0] OP_INQUIRY    = 8'h12;
    localparam logic [7:0] OP_PREVENT    = 8'h1E;
    localparam logic [7:0] OP_READ_CAP   = 8'h25;
    localparam logic [7:0] OP_READ10     = 8'h28;
    localparam logic [7:0] OP_READ_TOC   = 8'h43;

    // sense codes
    localparam logic [7:0] SK_NOT_READY   = 8'h02;
    localparam logic [7:0] SK_ILLEGAL     = 8'h05;
    localparam logic [7:0] ASC_NO_MEDIUM  = 8'h3A;
    localparam logic [7:0] ASC_BAD_LBA    = 8'h21;
    localparam logic [7:0] ASC_BAD_OPCODE = 8'h20;

    localparam logic [7:0] STAT_DATA  = 8'h08;
    localparam logic [7:0] STAT_READY = 8'h40;

    localparam int PREGAP_FRAMES = 150;

    // first nine command bytes, byte 0 in the low lane
    typedef logic [8:0][7:0] t_cdb;

    // decode outcome of a complete packet
    typedef struct packed {
        logic        start;
        logic [27:0] len;
        logic        media;
        logic        patch;
        t_kind       kind;
        logic        msf;
        logic        sense_wr;
        logic [7:0]  key;
        logic [7:0]  asc;
        logic [7:0]  ascq;
    } t_dec;

    function automatic logic [7:0] vendor_byte(input logic [2:0] k);
        case (k)
            3'd0: vendor_byte = 8'h42;
            3'd1: vendor_byte = 8'h45;
            3'd2: vendor_byte = 8'h4C;
            3'd3: vendor_byte = 8'h4C;
            3'd4: vendor_byte = 8'h41;
            3'd5: vendor_byte = 8'h54;
            3'd6: vendor_byte = 8'h52;
            default: vendor_byte = 8'h49;
        endcase
    endfunction

    function automatic logic [7:0] product_byte(input logic [3:0] k);
        case (k)
            4'd0: product_byte = 8'h56;
            4'd1: product_byte = 8'h49;
            4'd2: product_byte = 8'h52;
            4'd3: product_byte = 8'h54;
            4'd4: product_byte = 8'h55;
            4'd5: product_byte = 8'h41;
            4'd6: product_byte = 8'h4C;
            4'd7: product_byte = 8'h20;
            4'd8: product_byte = 8'h43;
            4'd9: product_byte = 8'h44;
            4'd10: product_byte = 8'h2D;
            4'd11: product_byte = 8'h52;
            4'd12: product_byte = 8'h4F;
            4'd13: product_byte = 8'h4D;
            default: product_byte = 8'h20;
        endcase
    endfunction

    // system identifier that replaces bytes 8..17 of the boot sector
    function automatic logic [7:0] boot_byte(input logic [3:0] k);
        case (k)
            4'd0: boot_byte = 8'h41;
            4'd1: boot_byte = 8'h4D;
            4'd2: boot_byte = 8'h49;
            4'd3: boot_byte = 8'h47;
            4'd4: boot_byte = 8'h41;
            4'd5: boot_byte = 8'h20;
            4'd6: boot_byte = 8'h42;
            4'd7: boot_byte = 8'h4F;
            4'd8: boot_byte = 8'h4F;
            4'd9: boot_byte = 8'h54;
            default: boot_byte = 8'h20;
        endcase
    endfunction

    // one byte of the response store, generated from the captured fields
    function automatic logic [7:0] resp_byte(
        input t_kind       kind,
        input logic        msf,
        input logic [5:0]  idx,
        input logic [7:0]  key,
        input logic [7:0]  asc,
        input logic [7:0]  ascq,
        input logic [19:0] sc,
        input logic [7:0]  mm,
        input logic [7:0]  ss,
        input logic [7:0]  ff,
        input logic [31:0] sb
    );
        logic [31:0] last;
        logic [31:0] lead;
        last = {12'd0, sc} - 32'd1;
        lead = {12'd0, sc};
        resp_byte = 8'h00;
        case (kind)
            K_SENSE: begin
                case (idx)
                    6'd0:  resp_byte = 8'h70;
                    6'd2:  resp_byte = key;
                    6'd7:  resp_byte = 8'd10;
                    6'd12: resp_byte = asc;
                    6'd13: resp_byte = ascq;
                    default: resp_byte = 8'h00;
                endcase
            end
            K_INQ: begin
                if (idx >= 6'd8 && idx < 6'd16) begin
                    resp_byte = vendor_byte(idx[2:0]);
                end else if (idx >= 6'd16 && idx < 6'd32) begin
                    resp_byte = product_byte(idx[3:0]);
                end else begin
                    case (idx)
                        6'd0: resp_byte = 8'h05;
                        6'd1: resp_byte = 8'h80;
                        6'd3: resp_byte = 8'h21;
                        6'd4: resp_byte = 8'd31;
                        default: resp_byte = 8'h00;
                    endcase
                end
            end
            K_CAP: begin
                case (idx)
                    6'd0: resp_byte = last[31:24];
                    6'd1: resp_byte = last[23:16];
                    6'd2: resp_byte = last[15:8];
                    6'd3: resp_byte = last[7:0];
                    6'd4: resp_byte = sb[31:24];
                    6'd5: resp_byte = sb[23:16];
                    6'd6: resp_byte = sb[15:8];
                    6'd7: resp_byte = sb[7:0];
                    default: resp_byte = 8'h00;
                endcase
            end
            default: begin
                case (idx)
                    6'd1:  resp_byte = 8'h12;
                    6'd2:  resp_byte = 8'h01;
                    6'd3:  resp_byte = 8'h01;
                    6'd5:  resp_byte = 8'h14;
                    6'd6:  resp_byte = 8'h01;
                    // track 1 start: 00:02:00 in msf form, lba 0 otherwise
                    6'd10: resp_byte = msf ? 8'd2 : 8'h00;
                    6'd13: resp_byte = 8'h14;
                    6'd14: resp_byte = 8'hAA;
                    6'd16: resp_byte = msf ? 8'h00 : lead[31:24];
                    6'd17: resp_byte = msf ? mm : lead[23:16];
                    6'd18: resp_byte = msf ? ss : lead[15:8];
                    6'd19: resp_byte = msf ? ff : lead[7:0];
                    default: resp_byte = 8'h00;
                endcase
            end
        endcase
    endfunction

endpackage

FILE: rtl/core/acp_decode.sv
// command packet decoder: validity checks and transfer setup
module acp_decode
    import acp_pkg::*;
#(
    parameter int SECTOR_BYTES = 2048
) (
    input  t_cdb        i_cdb,
    input  logic        i_media_present,
    input  logic [19:0] i_sector_count,
    input  logic [27:0] i_buffer_capacity,
    output t_dec        o_dec
);

    logic [31:0] lba;
    logic [15:0] cnt;
    logic [28:0] total;
    logic [32:0] end_lba;

    assign lba     = {i_cdb[2], i_cdb[3], i_cdb[4], i_cdb[5]};
    assign cnt     = {i_cdb[7], i_cdb[8]};
    assign total   = 29'(cnt) * 29'(SECTOR_BYTES);
    assign end_lba = 33'(lba) + 33'(cnt);

    always_comb begin
        o_dec          = '0;
        o_dec.kind     = K_SENSE;
        unique case (i_cdb[0])
            OP_TEST_READY: begin
                o_dec.sense_wr = 1'b1;
                if (!i_media_present) begin
                    o_dec.key = SK_NOT_READY;
                    o_dec.asc = ASC_NO_MEDIUM;
                end
            end
            OP_REQ_SENSE: begin
                o_dec.sense_wr = 1'b1;
                o_dec.start    = 1'b1;
                o_dec.kind     = K_SENSE;
                o_dec.len      = (i_cdb[4] < 8'd18) ? 28'(i_cdb[4]) : 28'd18;
            end
            OP_INQUIRY: begin
                o_dec.start = 1'b1;
                o_dec.kind  = K_INQ;
                o_dec.len   = (i_cdb[4] < 8'd36) ? 28'(i_cdb[4]) : 28'd36;
            end
            OP_PREVENT: begin
                o_dec.sense_wr = 1'b1;
            end
            OP_READ_CAP: begin
                o_dec.start = 1'b1;
                o_dec.kind  = K_CAP;
                o_dec.len   = 28'd8;
            end
            OP_READ10: begin
                // range check against capacity, media and the lead-out
                if (total > 29'(i_buffer_capacity) || !i_media_present ||
                    end_lba > 33'(i_sector_count)) begin
                    o_dec.sense_wr = 1'b1;
                    o_dec.key      = SK_ILLEGAL;
                    o_dec.asc      = ASC_BAD_LBA;
                end else begin
                    o_dec.start = 1'b1;
                    o_dec.media = 1'b1;
                    o_dec.patch = (lba == 32'd16) && (cnt != 16'd0) && (total >= 29'd40);
                    o_dec.len   = total[27:0];
                end
            end
            OP_READ_TOC: begin
                if (i_cdb[2][3:0] != 4'd0) begin
                    o_dec.sense_wr = 1'b1;
                    o_dec.key      = SK_ILLEGAL;
                    o_dec.asc      = ASC_BAD_OPCODE;
                end else begin
                    o_dec.start = 1'b1;
                    o_dec.kind  = K_TOC;
                    o_dec.msf   = i_cdb[1][1];
                    o_dec.len   = (cnt < 16'd20) ? 28'(cnt) : 28'd20;
                end
            end
            default: begin
                o_dec.sense_wr = 1'b1;
                o_dec.key      = SK_ILLEGAL;
                o_dec.asc      = ASC_BAD_OPCODE;
            end
        endcase
    end

endmodule

FILE: rtl/core/acp_msf.sv
// four-stage minute/second/frame conversion of the lead-out address
module acp_msf
    import acp_pkg::*;
(
    input  logic        i_clk,
    input  logic [19:0] i_lba,
    output logic [7:0]  o_min,
    output logic [7:0]  o_sec,
    output logic [7:0]  o_frm
);

    // reciprocals: floor(2^28/75) and floor(2^20/60), estimate low by at most one
    localparam logic [21:0] RECIP75 = 22'd3579139;
    localparam logic [14:0] RECIP60 = 15'd17476;

    logic [20:0] t;
    logic [42:0] p75;
    logic [13:0] r_q1e;
    logic [20:0] r_t1;
    logic [20:0] rem75;
    logic [13:0] n_q2;
    logic [6:0]  n_f2;
    logic [13:0] r_q2;
    logic [6:0]  r_f2;
    logic [28:0] p60;
    logic [7:0]  r_q3e;
    logic [13:0] r_q3;
    logic [6:0]  r_f3;
    logic [13:0] rem60;

    assign t   = 21'(i_lba) + 21'(PREGAP_FRAMES);
    assign p75 = 43'(t) * 43'(RECIP75);

    // stage 1: quotient estimate by 75
    always_ff @(posedge i_clk) begin
        r_q1e <= p75[41:28];
        r_t1  <= t;
    end

    // stage 2: correct quotient and frame remainder
    always_comb begin
        rem75 = r_t1 - 21'(r_q1e) * 21'd75;
        if (rem75 >= 21'd75) begin
            n_q2 = r_q1e + 14'd1;
            n_f2 = 7'(rem75 - 21'd75);
        end else begin
            n_q2 = r_q1e;
            n_f2 = 7'(rem75);
        end
    end

    always_ff @(posedge i_clk) begin
        r_q2 <= n_q2;
        r_f2 <= n_f2;
    end

    assign p60 = 29'(r_q2) * 29'(RECIP60);

    // stage 3: quotient estimate by 60
    always_ff @(posedge i_clk) begin
        r_q3e <= p60[27:20];
        r_q3  <= r_q2;
        r_f3  <= r_f2;
    end

    assign rem60 = r_q3 - 14'(r_q3e) * 14'd60;

    // stage 4: correct minutes and seconds
    always_ff @(posedge i_clk) begin
        if (rem60 >= 14'd60) begin
            o_min <= r_q3e + 8'd1;
            o_sec <= 8'(rem60 - 14'd60);
        end else begin
            o_min <= r_q3e;
            o_sec <= 8'(rem60);
        end
        o_frm <= 8'(r_f3);
    end

endmodule

FILE: rtl/core/atapi_cdrom_packet_device.sv
// ATAPI CD-ROM packet device: top level with device state and result register
//
// Every accepted host action updates the device state and loads its result
// into the output register at the same clock edge, so one action
// can be taken each cycle while the result side keeps up; a stalled result
// holds the input off only while the output register is full. The input
// stall is set by the output side alone. READ TOC in MSF form takes its
// lead-out from a four-stage conversion pipeline fed by the sector count
// captured at decode; those bytes are read no earlier than eight transfers
// later, well after the pipeline has settled. Configuration writes are taken
// in any cycle (ready is always high).
module atapi_cdrom_packet_device
    import acp_pkg::*;
#(
    parameter int PACKET_BYTES   = 12,
    parameter int SECTOR_BYTES   = 2048,
    parameter int RESPONSE_BYTES = 36
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_action,
    input  logic [15:0] i_word,
    input  logic [15:0] i_media_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_accepted,
    output logic [15:0] o_data_word,
    output logic [7:0]  o_status_byte,
    output logic        o_error_bit,
    output logic        o_has_data,
    output logic        o_disc_changed,
    output logic [27:0] o_remaining_bytes,
    output logic [1:0]  o_phase,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [27:0] i_cfg_data
);

    localparam int IW = $clog2(PACKET_BYTES + 1);
    localparam logic [IW-1:0] PKT_END = IW'(PACKET_BYTES);

    // configuration
    logic        r_media_present;
    logic [19:0] r_sector_count;
    logic [27:0] r_buffer_capacity;

    // device state
    t_phase      r_phase, n_phase;
    logic [7:0]  r_pkt [PACKET_BYTES];
    logic [7:0]  n_pkt [PACKET_BYTES];
    logic [IW-1:0] r_idx, n_idx;
    logic [7:0]  r_key, n_key, r_asc, n_asc, r_ascq, n_ascq;
    logic [27:0] r_len, n_len;
    logic [28:0] r_pos, n_pos;
    logic        r_media, n_media, r_patch, n_patch, r_changed, n_changed;

    // captured response store contents
    t_kind       r_kind, n_kind;
    logic        r_msf, n_msf;
    logic [7:0]  r_snap_key, n_snap_key, r_snap_asc, n_snap_asc;
    logic [7:0]  r_snap_ascq, n_snap_ascq;
    logic [19:0] r_snap_sc, n_snap_sc;

    logic        accept;
    t_action     act;
    logic [IW-1:0] idx1, idx2;
    t_cdb        cdb;
    t_dec        dec;
    logic [7:0]  toc_min, toc_sec, toc_frm;
    logic [28:0] pos_hi;
    logic [7:0]  byte_hi, byte_lo;
    logic        n_accepted;
    logic [15:0] n_data;

    assign accept      = i_in_valid && !o_in_stall;
    assign o_in_stall  = o_out_valid && i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign act         = t_action'(i_action);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_media_present   <= 1'b0;
            r_sector_count    <= '0;
            r_buffer_capacity <= 28'd65536;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MEDIA:    r_media_present   <= i_cfg_data[0];
                CFG_SECTORS:  r_sector_count    <= i_cfg_data[19:0];
                CFG_CAPACITY: r_buffer_capacity <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // packet index steps: high byte then low byte, both stop at the end
    assign idx1 = (r_idx < PKT_END) ? r_idx + IW'(1) : r_idx;
    assign idx2 = (idx1 < PKT_END) ? idx1 + IW'(1) : idx1;

    always_comb begin
        for (int k = 0; k < PACKET_BYTES; k++) begin
            n_pkt[k] = r_pkt[k];
            if (r_idx == IW'(k)) begin
                n_pkt[k] = i_word[15:8];
            end
            if (idx1 == IW'(k) && idx1 != r_idx) begin
                n_pkt[k] = i_word[7:0];
            end
        end
        for (int k = 0; k < 9; k++) begin
            cdb[k] = n_pkt[k];
        end
    end

    acp_decode #(
        .SECTOR_BYTES(SECTOR_BYTES)
    ) u_decode (
        .i_cdb            (cdb),
        .i_media_present  (r_media_present),
        .i_sector_count   (r_sector_count),
        .i_buffer_capacity(r_buffer_capacity),
        .o_dec            (dec)
    );

    acp_msf u_msf (
        .i_clk(i_clk),
        .i_lba(r_snap_sc),
        .o_min(toc_min),
        .o_sec(toc_sec),
        .o_frm(toc_frm)
    );

    // data bytes at the current position
    assign pos_hi = r_pos + 29'd1;

    function automatic logic [7:0] pick_byte(
        input logic [28:0] i,
        input logic        media,
        input logic        patch,
        input logic [7:0]  mb,
        input t_kind       kind,
        input logic        msf,
        input logic [7:0]  key,
        input logic [7:0]  asc,
        input logic [7:0]  ascq,
        input logic [19:0] sc,
        input logic [7:0]  mm,
        input logic [7:0]  ss,
        input logic [7:0]  ff
    );
        logic [28:0] k;
        k = i - 29'd8;
        if (media) begin
            if (patch && i >= 29'd8 && i < 29'd40) begin
                pick_byte = (k < 29'd10) ? boot_byte(k[3:0]) : 8'h20;
            end else begin
                pick_byte = mb;
            end
        end else if (i < 29'(RESPONSE_BYTES)) begin
            pick_byte = resp_byte(kind, msf, 6'(i), key, asc, ascq, sc, mm, ss, ff,
                                  32'(SECTOR_BYTES));
        end else begin
            pick_byte = 8'h00;
        end
    endfunction

    assign byte_hi = pick_byte(r_pos, r_media, r_patch, i_media_word[15:8], r_kind, r_msf,
                               r_snap_key, r_snap_asc, r_snap_ascq, r_snap_sc,
                               toc_min, toc_sec, toc_frm);
    assign byte_lo = pick_byte(pos_hi, r_media, r_patch, i_media_word[7:0], r_kind, r_msf,
                               r_snap_key, r_snap_asc, r_snap_ascq, r_snap_sc,
                               toc_min, toc_sec, toc_frm);

    // next state and result for one action
    always_comb begin
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_key       = r_key;
        n_asc       = r_asc;
        n_ascq      = r_ascq;
        n_len       = r_len;
        n_pos       = r_pos;
        n_media     = r_media;
        n_patch     = r_patch;
        n_changed   = r_changed;
        n_kind      = r_kind;
        n_msf       = r_msf;
        n_snap_key  = r_snap_key;
        n_snap_asc  = r_snap_asc;
        n_snap_ascq = r_snap_ascq;
        n_snap_sc   = r_snap_sc;
        n_accepted  = 1'b0;
        n_data      = 16'd0;
        case (act)
            ACT_RESET: begin
                n_phase   = PH_IDLE;
                n_idx     = '0;
                n_len     = '0;
                n_pos     = '0;
                n_media   = 1'b0;
                n_patch   = 1'b0;
                n_key     = '0;
                n_asc     = '0;
                n_ascq    = '0;
                n_changed = 1'b1;
            end
            ACT_BEGIN: begin
                n_phase = PH_PACKET;
                n_idx   = '0;
            end
            ACT_WORD: begin
                if (r_phase == PH_PACKET) begin
                    n_accepted = 1'b1;
                    n_idx      = idx2;
                    if (idx2 >= PKT_END) begin
                        // packet complete: capture store contents and decode
                        n_media     = dec.media;
                        n_patch     = dec.patch;
                        n_kind      = dec.kind;
                        n_msf       = dec.msf;
                        n_snap_key  = r_key;
                        n_snap_asc  = r_asc;
                        n_snap_ascq = r_ascq;
                        n_snap_sc   = r_sector_count;
                        if (dec.sense_wr) begin
                            n_key  = dec.key;
                            n_asc  = dec.asc;
                            n_ascq = dec.ascq;
                        end
                        if (dec.start) begin
                            n_len   = dec.len;
                            n_pos   = '0;
                            n_phase = PH_DATA;
                        end else begin
                            n_phase = PH_STATUS;
                        end
                    end
                end
            end
            ACT_READ: begin
                if (r_phase == PH_DATA && r_pos < 29'(r_len)) begin
                    n_data = {byte_hi, byte_lo};
                    n_pos  = r_pos + 29'd2;
                    if (n_pos >= 29'(r_len)) begin
                        n_phase = PH_STATUS;
                    end
                end
            end
            ACT_CLEAR: begin
                n_changed = 1'b0;
            end
            default: ;
        endcase
    end

    // phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (accept) begin
            r_phase <= n_phase;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_key     <= '0;
            r_asc     <= '0;
            r_ascq    <= '0;
            r_len     <= '0;
            r_pos     <= '0;
            r_media   <= 1'b0;
            r_patch   <= 1'b0;
            r_changed <= 1'b1;
        end else if (accept) begin
            r_idx     <= n_idx;
            r_key     <= n_key;
            r_asc     <= n_asc;
            r_ascq    <= n_ascq;
            r_len     <= n_len;
            r_pos     <= n_pos;
            r_media   <= n_media;
            r_patch   <= n_patch;
            r_changed <= n_changed;
        end
    end

    // packet bytes and captured response fields
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int k = 0; k < PACKET_BYTES; k++) begin
                r_pkt[k] <= n_pkt[k];
            end
            r_kind      <= n_kind;
            r_msf       <= n_msf;
            r_snap_key  <= n_snap_key;
            r_snap_asc  <= n_snap_asc;
            r_snap_ascq <= n_snap_ascq;
            r_snap_sc   <= n_snap_sc;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (accept) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            o_accepted        <= n_accepted;
            o_data_word       <= n_data;
            o_status_byte     <= (n_phase == PH_DATA) ? STAT_DATA : STAT_READY;
            o_error_bit       <= (n_key != 8'd0);
            o_has_data        <= (n_phase == PH_DATA) && (n_pos < 29'(n_len));
            o_disc_changed    <= n_changed;
            o_remaining_bytes <= (29'(n_len) > n_pos) ? 28'(29'(n_len) - n_pos) : 28'd0;
            o_phase           <= n_phase;
        end
    end

endmodule

FILE: rtl/core/acp_checker.sv
// port-level checks of the packet device and their binding to the top level
module acp_checker
    import acp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_accepted,
    input logic [15:0] o_data_word,
    input logic [7:0]  o_status_byte,
    input logic        o_has_data,
    input logic [27:0] o_remaining_bytes,
    input logic [1:0]  o_phase
);

    // a stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_data_word))
        else $error("stalled result changed");

    // pending data implies data phase, data status and a nonzero count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_has_data |->
            o_phase == PH_DATA && o_status_byte == STAT_DATA && o_remaining_bytes != 28'd0)
        else $error("has_data without a live transfer");

    // outside data phase the status is ready
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_phase != PH_DATA |-> o_status_byte == STAT_READY)
        else $error("status byte disagrees with phase");

    // a packet word transfer never returns read data
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_accepted |-> o_data_word == 16'd0)
        else $error("data word on packet transfer");

endmodule

bind atapi_cdrom_packet_device acp_checker u_acp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_accepted       (o_accepted),
    .o_data_word      (o_data_word),
    .o_status_byte    (o_status_byte),
    .o_has_data       (o_has_data),
    .o_remaining_bytes(o_remaining_bytes),
    .o_phase          (o_phase)
);

FILE: tb/atapi_cdrom_packet_device_test.sv
// testbench for the atapi cd-rom packet device: directed and random host traffic checked against a predictor
`timescale 1ns / 100ps

module atapi_cdrom_packet_device_test;
    import acp_pkg::*;

    typedef logic [7:0] cdb_t [12];

    typedef struct {
        logic [2:0]  act;
        logic [15:0] word;
        logic [15:0] mword;
    } host_access_t;

    typedef struct {
        logic        accepted;
        logic [15:0] data_word;
        logic [7:0]  status_byte;
        logic        error_bit;
        logic        has_data;
        logic        disc_changed;
        logic [27:0] remaining;
        logic [1:0]  phase;
    } device_status_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_action;
    logic [15:0] i_word;
    logic [15:0] i_media_word;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_accepted;
    logic [15:0] o_data_word;
    logic [7:0]  o_status_byte;
    logic        o_error_bit;
    logic        o_has_data;
    logic        o_disc_changed;
    logic [27:0] o_remaining_bytes;
    logic [1:0]  o_phase;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [27:0] i_cfg_data;

    atapi_cdrom_packet_device DUT (.*);

    // fixed identification bytes
    localparam logic [7:0] VENDOR [8] = '{8'h42, 8'h45, 8'h4C, 8'h4C, 8'h41, 8'h54, 8'h52, 8'h49};
    localparam logic [7:0] PRODUCT [16] = '{8'h56, 8'h49, 8'h52, 8'h54, 8'h55, 8'h41, 8'h4C,
        8'h20, 8'h43, 8'h44, 8'h2D, 8'h52, 8'h4F, 8'h4D, 8'h20, 8'h20};
    localparam logic [7:0] SYSTEM_ID [10] = '{8'h41, 8'h4D, 8'h49, 8'h47, 8'h41, 8'h20, 8'h42,
        8'h4F, 8'h4F, 8'h54};

    // predicted device state
    logic        media_on;
    logic [19:0] sectors;
    logic [27:0] capacity;
    t_phase      dev_phase;
    logic [7:0]  cmd_bytes [12];
    int unsigned cmd_fill;
    logic [7:0]  sns_key, sense_asc, sense_ascq;
    logic [7:0]  reply [36];
    logic [27:0] xfer_len;
    logic [28:0] xfer_pos;
    logic        xfer_media;
    logic        patch_id;
    logic        changed;

    host_access_t   pending_q [$];
    device_status_t expected_q [$];
    host_access_t   cur;
    int unsigned    error_count = 0;
    int unsigned    pushed = 0;
    bit             taken = 0;
    int unsigned    burst_left = 1;
    int unsigned    gap_left = 0;
    int unsigned    stall_mode = 0;
    int unsigned    mode_left = 100;

    task automatic load_sense(input logic [7:0] k, input logic [7:0] c, input logic [7:0] q);
        sns_key = k;
        sense_asc = c;
        sense_ascq = q;
    endtask

    task automatic begin_data(input logic [27:0] len, input logic media);
        xfer_len = len;
        xfer_pos = '0;
        xfer_media = media;
        dev_phase = PH_DATA;
    endtask

    task automatic put_word32(input int at, input logic [31:0] v);
        reply[at] = v[31:24];
        reply[at+1] = v[23:16];
        reply[at+2] = v[15:8];
        reply[at+3] = v[7:0];
    endtask

    task automatic put_time(input int at, input logic [31:0] lba);
        logic [31:0] t;
        t = lba + 32'd150;
        reply[at] = 8'h00;
        reply[at+3] = 8'(t % 75);
        t = t / 75;
        reply[at+2] = 8'(t % 60);
        reply[at+1] = 8'(t / 60);
    endtask

    task automatic dev_reset();
        dev_phase = PH_IDLE;
        cmd_fill = 0;
        xfer_len = '0;
        xfer_pos = '0;
        xfer_media = 0;
        patch_id = 0;
        load_sense(8'h00, 8'h00, 8'h00);
        changed = 1;
    endtask

    // decode a complete command packet
    task automatic run_command();
        logic [31:0] lba;
        logic [15:0] cnt;
        logic [63:0] total;
        logic        msf;
        for (int i = 0; i < 36; i++) reply[i] = 8'h00;
        patch_id = 0;
        xfer_media = 0;
        case (cmd_bytes[0])
            OP_TEST_READY: begin
                if (media_on) load_sense(8'h00, 8'h00, 8'h00);
                else load_sense(SK_NOT_READY, ASC_NO_MEDIUM, 8'h00);
                dev_phase = PH_STATUS;
            end
            OP_REQ_SENSE: begin
                reply[0] = 8'h70;
                reply[2] = sns_key;
                reply[7] = 8'd10;
                reply[12] = sense_asc;
                reply[13] = sense_ascq;
                load_sense(8'h00, 8'h00, 8'h00);
                begin_data((cmd_bytes[4] < 18) ? 28'(cmd_bytes[4]) : 28'd18, 0);
            end
            OP_INQUIRY: begin
                reply[0] = 8'h05;
                reply[1] = 8'h80;
                reply[3] = 8'h21;
                reply[4] = 8'd31;
                for (int i = 0; i < 8; i++) reply[8+i] = VENDOR[i];
                for (int i = 0; i < 16; i++) reply[16+i] = PRODUCT[i];
                begin_data((cmd_bytes[4] < 36) ? 28'(cmd_bytes[4]) : 28'd36, 0);
            end
            OP_PREVENT: begin
                load_sense(8'h00, 8'h00, 8'h00);
                dev_phase = PH_STATUS;
            end
            OP_READ_CAP: begin
                put_word32(0, {12'd0, sectors} - 32'd1);
                put_word32(4, 32'd2048);
                begin_data(28'd8, 0);
            end
            OP_READ10: begin
                lba = {cmd_bytes[2], cmd_bytes[3], cmd_bytes[4], cmd_bytes[5]};
                cnt = {cmd_bytes[7], cmd_bytes[8]};
                total = 64'(cnt) * 64'd2048;
                if (total > 64'(capacity) || !media_on || 64'(lba) + 64'(cnt) > 64'(sectors))
                begin
                    load_sense(SK_ILLEGAL, ASC_BAD_LBA, 8'h00);
                    dev_phase = PH_STATUS;
                end else begin
                    patch_id = (lba == 32'd16 && cnt >= 1 && total >= 40);
                    begin_data(28'(total), 1);
                end
            end
            OP_READ_TOC: begin
                msf = cmd_bytes[1][1];
                if (cmd_bytes[2][3:0] != 4'd0) begin
                    load_sense(SK_ILLEGAL, ASC_BAD_OPCODE, 8'h00);
                    dev_phase = PH_STATUS;
                end else begin
                    reply[1] = 8'h12;
                    reply[2] = 8'h01;
                    reply[3] = 8'h01;
                    reply[5] = 8'h14;
                    reply[6] = 8'h01;
                    if (msf) put_time(8, 32'd0); else put_word32(8, 32'd0);
                    reply[13] = 8'h14;
                    reply[14] = 8'hAA;
                    if (msf) put_time(16, {12'd0, sectors});
                    else put_word32(16, {12'd0, sectors});
                    cnt = {cmd_bytes[7], cmd_bytes[8]};
                    begin_data((cnt < 20) ? 28'(cnt) : 28'd20, 0);
                end
            end
            default: begin
                load_sense(SK_ILLEGAL, ASC_BAD_OPCODE, 8'h00);
                dev_phase = PH_STATUS;
            end
        endcase
    endtask

    function automatic logic [7:0] reply_byte(input logic [28:0] i);
        return (i < 36) ? reply[i] : 8'h00;
    endfunction

    function automatic logic [7:0] disc_byte(input logic [28:0] i, input logic [7:0] b);
        if (patch_id && i >= 8 && i < 40) return (i - 8 < 10) ? SYSTEM_ID[i-8] : 8'h20;
        return b;
    endfunction

    // advance the predicted state by one host access and queue the expected status
    task automatic predict_access(input host_access_t a);
        device_status_t r;
        logic [7:0] hi, lo;
        r = '{default: '0};
        case (a.act)
            ACT_RESET: dev_reset();
            ACT_BEGIN: begin
                dev_phase = PH_PACKET;
                cmd_fill = 0;
            end
            ACT_WORD: begin
                if (dev_phase == PH_PACKET) begin
                    r.accepted = 1;
                    if (cmd_fill < 12) begin
                        cmd_bytes[cmd_fill] = a.word[15:8];
                        cmd_fill++;
                    end
                    if (cmd_fill < 12) begin
                        cmd_bytes[cmd_fill] = a.word[7:0];
                        cmd_fill++;
                    end
                    if (cmd_fill >= 12) run_command();
                end
            end
            ACT_READ: begin
                if (dev_phase == PH_DATA && xfer_pos < {1'b0, xfer_len}) begin
                    if (xfer_media) begin
                        hi = disc_byte(xfer_pos, a.mword[15:8]);
                        lo = disc_byte(xfer_pos + 29'd1, a.mword[7:0]);
                    end else begin
                        hi = reply_byte(xfer_pos);
                        lo = reply_byte(xfer_pos + 29'd1);
                    end
                    r.data_word = {hi, lo};
                    xfer_pos = xfer_pos + 29'd2;
                    if (xfer_pos >= {1'b0, xfer_len}) dev_phase = PH_STATUS;
                end
            end
            ACT_CLEAR: changed = 0;
            default: ;
        endcase
        r.status_byte = (dev_phase == PH_DATA) ? STAT_DATA : STAT_READY;
        r.error_bit = (sns_key != 0);
        r.has_data = (dev_phase == PH_DATA) && (xfer_pos < {1'b0, xfer_len});
        r.disc_changed = changed;
        r.remaining = ({1'b0, xfer_len} > xfer_pos) ? 28'({1'b0, xfer_len} - xfer_pos) : '0;
        r.phase = dev_phase;
        expected_q.push_back(r);
    endtask

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
        error_count++;
    endtask

    task automatic compare_field(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) report(field, got, want);
    endtask

    // clock
    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // sender: one access per transfer, bursts mostly separated by gaps
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || taken)) begin
            taken = 0;
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 0;
            end else if (pending_q.size() > 0) begin
                cur = pending_q.pop_front();
                i_action <= cur.act;
                i_word <= cur.word;
                i_media_word <= cur.mword;
                i_in_valid <= 1;
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_in_valid <= 0;
            end
        end
    end

    // receiver stall pattern, switching between modes
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(30, 250);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: i_out_stall <= 0;
            1: i_out_stall <= $urandom_range(0, 1);
            2: i_out_stall <= ($urandom_range(0, 7) != 0);
            default: i_out_stall <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // accepted transfers on both channels
    always @(posedge i_clk) begin
        device_status_t w;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            predict_access(cur);
            taken = 1;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                report("unexpected result", 32'h0, 32'h0);
            end else begin
                w = expected_q.pop_front();
                compare_field("accepted", o_accepted, w.accepted);
                compare_field("data_word", o_data_word, w.data_word);
                compare_field("status_byte", o_status_byte, w.status_byte);
                compare_field("error_bit", o_error_bit, w.error_bit);
                compare_field("has_data", o_has_data, w.has_data);
                compare_field("disc_changed", o_disc_changed, w.disc_changed);
                compare_field("remaining_bytes", o_remaining_bytes, w.remaining);
                compare_field("phase", o_phase, w.phase);
            end
        end
    end

    task automatic push_access(input logic [2:0] act, input logic [15:0] w);
        host_access_t a;
        a.act = act;
        a.word = w;
        a.mword = 16'($urandom);
        pending_q.push_back(a);
        pushed++;
    endtask

    // begin packet, send words of the packet, then read data words
    task automatic push_command(input cdb_t p, input int nwords, input int nreads);
        push_access(ACT_BEGIN, 16'($urandom));
        for (int i = 0; i < nwords; i++) push_access(ACT_WORD, {p[2*i], p[2*i+1]});
        for (int i = 0; i < nreads; i++) push_access(ACT_READ, 16'($urandom));
    endtask

    task automatic wait_idle();
        while (pending_q.size() != 0 || expected_q.size() != 0 || i_in_valid)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [27:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MEDIA:   media_on = val[0];
            CFG_SECTORS: sectors = val[19:0];
            default:     capacity = val;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic configure(input logic m, input logic [19:0] sc, input logic [27:0] cap);
        wait_idle();
        write_reg(CFG_MEDIA, {27'd0, m});
        write_reg(CFG_SECTORS, {8'd0, sc});
        write_reg(CFG_CAPACITY, cap);
    endtask

    // one random command, mostly well formed
    task automatic push_random_command();
        cdb_t p;
        int sel;
        logic [31:0] lba;
        logic [15:0] cnt;
        for (int i = 0; i < 12; i++) p[i] = 8'($urandom);
        sel = $urandom_range(0, 19);
        case (sel)
            0, 1:       p[0] = OP_TEST_READY;
            2, 3:       p[0] = OP_REQ_SENSE;
            4, 5:       p[0] = OP_INQUIRY;
            6:          p[0] = OP_PREVENT;
            7, 8:       p[0] = OP_READ_CAP;
            9, 10, 11, 12, 13: p[0] = OP_READ10;
            14, 15, 16: p[0] = OP_READ_TOC;
            default:    ;
        endcase
        if ($urandom_range(0, 2) != 0) p[4] = 8'($urandom_range(0, 40));
        if (p[0] == OP_READ10 && $urandom_range(0, 3) != 0) begin
            lba = ($urandom_range(0, 2) == 0) ? 32'd16 : $urandom_range(0, sectors + 2);
            cnt = 16'($urandom_range(0, 2));
            {p[2], p[3], p[4], p[5]} = lba;
            {p[7], p[8]} = cnt;
        end
        if (p[0] == OP_READ_TOC) begin
            if ($urandom_range(0, 3) != 0) p[2][3:0] = 4'd0;
            if ($urandom_range(0, 2) != 0) {p[7], p[8]} = 16'($urandom_range(0, 24));
        end
        // a few packets are cut short
        push_command(p, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : 6,
                     $urandom_range(0, 24));
    endtask

    task automatic random_phase(input int unsigned n);
        int unsigned stop;
        stop = pushed + n;
        while (pushed < stop) begin
            if ($urandom_range(0, 9) == 0) begin
                push_access(3'($urandom_range(0, 7)), 16'($urandom));
            end else begin
                push_random_command();
            end
        end
    endtask

    // stimulus and end of run
    initial begin
        i_rst_n = 0;
        i_in_valid = 0;
        i_action = ACT_RESET;
        i_word = '0;
        i_media_word = '0;
        i_out_stall = 0;
        i_cfg_valid = 0;
        i_cfg_index = CFG_MEDIA;
        i_cfg_data = '0;
        media_on = 0;
        sectors = '0;
        capacity = 28'd65536;
        for (int i = 0; i < 12; i++) cmd_bytes[i] = 8'h00;
        for (int i = 0; i < 36; i++) reply[i] = 8'h00;
        dev_reset();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed, reset settings: no medium
        push_access(ACT_WORD, 16'hFFFF);
        push_command('{OP_TEST_READY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 6, 1);
        push_command('{OP_REQ_SENSE, 0, 0, 0, 18, 0, 0, 0, 0, 0, 0, 0}, 6, 10);
        push_command('{OP_READ_CAP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 6, 4);
        push_command('{OP_READ10, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0}, 6, 1);
        push_command('{OP_INQUIRY, 0, 0, 0, 8'hFF, 0, 0, 0, 0, 0, 0, 0}, 6, 19);
        push_command('{OP_INQUIRY, 0, 0, 0, 7, 0, 0, 0, 0, 0, 0, 0}, 6, 5);
        push_command('{OP_REQ_SENSE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 6, 2);
        push_command('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                       8'hFF, 8'hFF, 8'hFF}, 6, 1);
        push_access(ACT_CLEAR, 16'h0000);
        push_access(3'd5, 16'h1234);
        push_access(3'd7, 16'hFFFF);
        push_access(ACT_RESET, 16'h0000);
        push_command('{OP_PREVENT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 6, 1);

        // directed, medium present
        configure(1, 20'd20, 28'd65536);
        push_command('{OP_READ10, 0, 0, 0, 0, 16, 0, 0, 1, 0, 0, 0}, 6, 24);
        push_command('{OP_READ10, 0, 0, 0, 0, 20, 0, 0, 1, 0, 0, 0}, 6, 1);
        push_command('{OP_READ10, 0, 0, 0, 0, 0, 0, 0, 40, 0, 0, 0}, 6, 1);
        push_command('{OP_READ10, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, 0, 0, 0, 0, 0}, 6, 2);
        push_command('{OP_READ10, 0, 0, 0, 0, 3, 0, 0, 0, 0, 0, 0}, 6, 2);
        push_command('{OP_READ_TOC, 0, 1, 0, 0, 0, 0, 0, 20, 0, 0, 0}, 6, 1);
        push_command('{OP_READ_TOC, 0, 0, 0, 0, 0, 0, 0, 20, 0, 0, 0}, 6, 11);
        push_command('{OP_READ_TOC, 2, 0, 0, 0, 0, 0, 8'hFF, 8'hFF, 0, 0, 0}, 6, 11);
        push_command('{OP_READ_TOC, 2, 0, 0, 0, 0, 0, 0, 19, 0, 0, 0}, 6, 11);
        push_command('{OP_REQ_SENSE, 0, 0, 0, 5, 0, 0, 0, 0, 0, 0, 0}, 6, 4);
        push_command('{OP_READ_CAP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 3, 2);

        // random phases through several settings
        random_phase(190);
        configure(1, 20'hFFFFF, 28'd134217728);
        push_command('{OP_READ10, 0, 0, 0, 0, 0, 0, 8'hFF, 8'hFF, 0, 0, 0}, 6, 3);
        push_command('{OP_READ_TOC, 2, 0, 0, 0, 0, 0, 0, 20, 0, 0, 0}, 6, 11);
        push_command('{OP_READ_CAP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 6, 4);
        random_phase(190);
        configure(1, 20'd0, 28'd0);
        random_phase(190);
        configure(0, 20'd100, 28'd2048);
        random_phase(190);
        configure(1, 20'd17, 28'd40960);
        random_phase(190);
        configure(1, 20'($urandom), 28'd1);
        random_phase(190);

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS atapi_cdrom_packet_device");
        end else begin
            $display("FAIL atapi_cdrom_packet_device");
        end
        $finish;
    end

    // overall time limit
    initial begin
        #2000000;
        $display("FAIL atapi_cdrom_packet_device");
        $finish;
    end

endmodule
